/* rtl/nbr_pkg.sv */
// Package for the nearest box ray distance block: widths, reset values,
// register indexes and the controller/datapath command and status structs.
// No dependencies.
package nbr_pkg;

    localparam int MaxBoxesDef = 16;

    localparam logic [23:0] MaxRangeRst    = 24'd204800;
    localparam logic [15:0] StartOffsetRst = 16'd0;
    localparam logic [4:0]  BoxCountRst    = 5'd0;

    // configuration register indexes
    localparam logic [1:0] RegMaxRange    = 2'd0;
    localparam logic [1:0] RegStartOffset = 2'd1;
    localparam logic [1:0] RegBoxCount    = 2'd2;

    // table entry layout: {left, top, width, height}
    localparam int EntryW = 94;

    // divider: 41 bit magnitude dividend, 41 steps
    localparam int DivSteps = 41;

    typedef struct packed {
        logic ld_cast;
        logic ld_origin;
        logic ld_box;
        logic axis;       // 0 = x, 1 = y
        logic edge_hi;    // divide the far edge
        logic div_start;
        logic save_t1;
        logic slab_apply;
        logic par_apply;
        logic box_eval;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic dir_zero_x;
        logic dir_zero_y;
    } t_sts;

endpackage

/* rtl/nbr_ram.sv */
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module nbr_ram #(
    parameter int Width = 8,
    parameter int Depth = 16,
    localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  logic [Width-1:0] i_wdata,
    input  logic [AddrW-1:0] i_raddr,
    output logic [Width-1:0] o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/nbr_datapath.sv */
// Datapath: ray origin, slab edges, shared restoring divider, interval
// narrowing and nearest-hit tracking. Depends on nbr_pkg.
module nbr_datapath import nbr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic signed [23:0]  i_centre_x,
    input  logic signed [23:0]  i_centre_y,
    input  logic signed [15:0]  i_dir_x,
    input  logic signed [15:0]  i_dir_y,
    input  logic [15:0]         i_start_offset,
    input  logic [23:0]         i_max_range,
    input  logic [EntryW-1:0]   i_entry,
    output logic [23:0]         o_best,
    output logic                o_hit
);

    logic signed [23:0] r_cx, r_cy;
    logic signed [15:0] r_dx, r_dy;
    logic signed [25:0] r_ox, r_oy;
    logic signed [24:0] r_xlo, r_xhi, r_ylo, r_yhi;
    logic signed [41:0] r_t1, r_lo, r_hi;
    logic               r_hi_inf, r_alive;
    logic [23:0]        r_best;
    logic               r_hit;

    // divider state
    logic [40:0]        r_quo;
    logic [15:0]        r_rem;
    logic [15:0]        r_dmag;
    logic               r_neg;
    logic [5:0]         r_cnt;
    logic               r_div_busy;

    logic signed [32:0] prod_x, prod_y;
    logic signed [18:0] sh_x, sh_y;
    logic signed [25:0] o_sel;
    logic signed [24:0] e_sel;
    logic signed [15:0] d_sel;
    logic signed [26:0] num;
    logic [26:0]        num_mag;
    logic [15:0]        d_mag;
    logic [16:0]        trial, diff;
    logic signed [41:0] quot, t_a, t_b;
    logic signed [24:0] ent_l, ent_t;
    logic signed [25:0] par_o;
    logic signed [24:0] par_lo, par_hi;
    logic               par_in;

    assign prod_x = r_dx * $signed({1'b0, i_start_offset});
    assign prod_y = r_dy * $signed({1'b0, i_start_offset});
    assign sh_x   = prod_x[32:14];
    assign sh_y   = prod_y[32:14];

    always_comb begin
        o_sel = i_cmd.axis ? r_oy : r_ox;
        d_sel = i_cmd.axis ? r_dy : r_dx;
        if (i_cmd.axis) begin
            e_sel = i_cmd.edge_hi ? r_yhi : r_ylo;
        end else begin
            e_sel = i_cmd.edge_hi ? r_xhi : r_xlo;
        end
        num     = {{2{e_sel[24]}}, e_sel} - {o_sel[25], o_sel};
        num_mag = num[26] ? 27'(-num) : 27'(num);
        d_mag   = d_sel[15] ? 16'(-d_sel) : 16'(d_sel);
        trial   = {r_rem, r_quo[40]};
        diff    = trial - {1'b0, r_dmag};
        quot    = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
        if (r_t1 > quot) begin
            t_a = quot;
            t_b = r_t1;
        end else begin
            t_a = r_t1;
            t_b = quot;
        end
        par_o  = i_cmd.axis ? r_oy : r_ox;
        par_lo = i_cmd.axis ? r_ylo : r_xlo;
        par_hi = i_cmd.axis ? r_yhi : r_xhi;
        par_in = !((par_o < 26'(par_lo)) || (par_o > 26'(par_hi)));
        ent_l  = 25'($signed(i_entry[93:70]));
        ent_t  = 25'($signed(i_entry[69:46]));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_cast) begin
            r_cx <= i_centre_x;
            r_cy <= i_centre_y;
            r_dx <= i_dir_x;
            r_dy <= i_dir_y;
        end
        if (i_cmd.ld_origin) begin
            r_ox   <= 26'(r_cx) + 26'(sh_x);
            r_oy   <= 26'(r_cy) + 26'(sh_y);
            r_best <= i_max_range;
            r_hit  <= 1'b0;
        end
        if (i_cmd.ld_box) begin
            r_xlo    <= ent_l;
            r_xhi    <= ent_l + $signed({2'b00, i_entry[45:23]});
            r_ylo    <= ent_t;
            r_yhi    <= ent_t + $signed({2'b00, i_entry[22:0]});
            r_lo     <= '0;
            r_hi     <= '0;
            r_hi_inf <= 1'b1;
            r_alive  <= 1'b1;
        end
        if (i_cmd.par_apply && !par_in) begin
            r_alive <= 1'b0;
        end
        if (i_cmd.save_t1) begin
            r_t1 <= quot;
        end
        if (i_cmd.slab_apply) begin
            if (t_a > r_lo) begin
                r_lo <= t_a;
            end
            if (r_hi_inf || (t_b < r_hi)) begin
                r_hi     <= t_b;
                r_hi_inf <= 1'b0;
            end
        end
        if (i_cmd.box_eval && r_alive && (r_hi_inf || !(r_hi < r_lo))
                && (r_lo < $signed({18'd0, r_best}))) begin
            r_best <= r_lo[23:0];
            r_hit  <= 1'b1;
        end
    end

    // shared restoring divider, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
        end else if (i_cmd.div_start) begin
            r_quo      <= {num_mag[26:0], 14'd0};
            r_rem      <= '0;
            r_dmag     <= d_mag;
            r_neg      <= num[26] ^ d_sel[15];
            r_cnt      <= 6'(DivSteps);
            r_div_busy <= 1'b1;
        end else if (r_div_busy) begin
            if (!diff[16]) begin
                r_rem <= diff[15:0];
                r_quo <= {r_quo[39:0], 1'b1};
            end else begin
                r_rem <= trial[15:0];
                r_quo <= {r_quo[39:0], 1'b0};
            end
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                r_div_busy <= 1'b0;
            end
        end
    end

    assign o_sts.div_busy   = r_div_busy;
    assign o_sts.dir_zero_x = (r_dx == 16'sd0);
    assign o_sts.dir_zero_y = (r_dy == 16'sd0);
    assign o_best = r_best;
    assign o_hit  = r_hit;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> !r_div_busy)
        else $error("divider restarted while busy");
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |=> r_div_busy && (r_cnt == 6'(DivSteps)))
        else $error("divider did not load");
    a_apply_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.slab_apply || i_cmd.save_t1) |-> !r_div_busy)
        else $error("quotient used while divider busy");

endmodule

/* rtl/nbr_ctrl.sv */
// Controller: sequences a cast over the box table, one box and one slab
// axis at a time, driving the datapath by command struct. Depends on nbr_pkg.
module nbr_ctrl import nbr_pkg::*; #(
    parameter int MaxBoxes = MaxBoxesDef,
    localparam int AddrW = (MaxBoxes > 1) ? $clog2(MaxBoxes) : 1,
    localparam int CntW  = $clog2(MaxBoxes + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cast_start,
    input  logic [4:0]       i_box_count,
    input  logic             i_out_free,
    input  t_sts             i_sts,
    output t_cmd             o_cmd,
    output logic             o_in_ready,
    output logic [AddrW-1:0] o_raddr
);

    typedef enum logic [3:0] {
        S_IDLE, S_ORIGIN, S_NEXT, S_LOAD, S_AXIS, S_WAIT1, S_WAIT2, S_EVAL, S_OUT
    } t_state;

    t_state          r_state, n_state;
    logic [CntW-1:0] r_idx, n_idx;
    logic [CntW-1:0] r_n, n_n;
    logic            r_axis, n_axis;
    logic            dir_zero;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_n     = r_n;
        n_axis  = r_axis;
        o_cmd   = '0;
        o_cmd.axis = r_axis;
        dir_zero = r_axis ? i_sts.dir_zero_y : i_sts.dir_zero_x;
        case (r_state)
            S_IDLE: begin
                if (i_cast_start) begin
                    o_cmd.ld_cast = 1'b1;
                    if ({27'd0, i_box_count} > 32'(MaxBoxes)) begin
                        n_n = CntW'(MaxBoxes);
                    end else begin
                        n_n = CntW'(i_box_count);
                    end
                    n_state = S_ORIGIN;
                end
            end
            S_ORIGIN: begin
                o_cmd.ld_origin = 1'b1;
                n_idx   = '0;
                n_state = S_NEXT;
            end
            S_NEXT: begin
                n_state = (r_idx == r_n) ? S_OUT : S_LOAD;
            end
            S_LOAD: begin
                o_cmd.ld_box = 1'b1;
                n_axis  = 1'b0;
                n_state = S_AXIS;
            end
            S_AXIS: begin
                if (dir_zero) begin
                    o_cmd.par_apply = 1'b1;
                    n_axis  = 1'b1;
                    n_state = r_axis ? S_EVAL : S_AXIS;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_WAIT1;
                end
            end
            S_WAIT1: begin
                if (!i_sts.div_busy) begin
                    o_cmd.save_t1   = 1'b1;
                    o_cmd.edge_hi   = 1'b1;
                    o_cmd.div_start = 1'b1;
                    n_state = S_WAIT2;
                end
            end
            S_WAIT2: begin
                if (!i_sts.div_busy) begin
                    o_cmd.slab_apply = 1'b1;
                    n_axis  = 1'b1;
                    n_state = r_axis ? S_EVAL : S_AXIS;
                end
            end
            S_EVAL: begin
                o_cmd.box_eval = 1'b1;
                n_idx   = r_idx + 1'b1;
                n_state = S_NEXT;
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_n     <= '0;
            r_axis  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_n     <= n_n;
            r_axis  <= n_axis;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_raddr    = r_idx[AddrW-1:0];

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NEXT) |-> (r_idx <= r_n))
        else $error("box index ran past box count");
    a_n_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= CntW'(MaxBoxes))
        else $error("box count not saturated");

endmodule

/* rtl/nearest_box_ray_distance.sv */
// Top level of the nearest box ray distance caster: config registers, box
// table, output register. Depends on nbr_pkg, nbr_ram, nbr_ctrl, nbr_datapath.
//
//  channel   signals                          direction
//  cfg       i_cfg_we/index/data               in, write only
//  in        i_in_valid/o_in_ready + fields    in, box write or cast
//  out       o_out_valid/i_out_ready + fields  out, one per cast
//
// A box write is taken only while the block is idle. A cast works through
// each box in use, one axis at a time: an axis with a nonzero direction
// component takes two 41 step divisions through one divider that makes one
// quotient bit a cycle, and a zero one a parallel check. Reset (synchronous,
// active low) clears control and config; the box table is undefined until
// written. A stalled result holds the block at its end until taken.
module nearest_box_ray_distance import nbr_pkg::*; #(
    parameter int MaxBoxes = MaxBoxesDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_action,
    input  logic [3:0]         i_box_index,
    input  logic signed [23:0] i_box_left,
    input  logic signed [23:0] i_box_top,
    input  logic [22:0]        i_box_width,
    input  logic [22:0]        i_box_height,
    input  logic signed [23:0] i_centre_x,
    input  logic signed [23:0] i_centre_y,
    input  logic signed [15:0] i_dir_x,
    input  logic signed [15:0] i_dir_y,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [23:0]        o_distance,
    output logic               o_hit
);

    localparam int AddrW = (MaxBoxes > 1) ? $clog2(MaxBoxes) : 1;

    logic [23:0] r_max_range;
    logic [15:0] r_start_offset;
    logic [4:0]  r_box_count;
    logic        r_out_valid;
    logic [23:0] r_distance;
    logic        r_hit;

    t_cmd              cmd;
    t_sts              sts;
    logic              in_acc, ram_we;
    logic [AddrW-1:0]  raddr;
    logic [EntryW-1:0] entry;
    logic [23:0]       best;
    logic              best_hit;

    assign in_acc = i_in_valid && o_in_ready;
    assign ram_we = in_acc && !i_action && ({28'd0, i_box_index} < 32'(MaxBoxes));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_range    <= MaxRangeRst;
            r_start_offset <= StartOffsetRst;
            r_box_count    <= BoxCountRst;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                RegMaxRange:    r_max_range    <= i_cfg_data;
                RegStartOffset: r_start_offset <= i_cfg_data[15:0];
                RegBoxCount:    r_box_count    <= i_cfg_data[4:0];
                default:        ;
            endcase
        end
    end

    nbr_ram #(.Width(EntryW), .Depth(MaxBoxes)) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AddrW'(i_box_index)),
        .i_wdata ({i_box_left, i_box_top, i_box_width, i_box_height}),
        .i_raddr (raddr),
        .o_rdata (entry)
    );

    nbr_ctrl #(.MaxBoxes(MaxBoxes)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cast_start (in_acc && i_action),
        .i_box_count  (r_box_count),
        .i_out_free   (!r_out_valid || i_out_ready),
        .i_sts        (sts),
        .o_cmd        (cmd),
        .o_in_ready   (o_in_ready),
        .o_raddr      (raddr)
    );

    nbr_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_centre_x     (i_centre_x),
        .i_centre_y     (i_centre_y),
        .i_dir_x        (i_dir_x),
        .i_dir_y        (i_dir_y),
        .i_start_offset (r_start_offset),
        .i_max_range    (r_max_range),
        .i_entry        (entry),
        .o_best         (best),
        .o_hit          (best_hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (cmd.out_load) begin
            r_distance <= best;
            r_hit      <= best_hit;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_distance  = r_distance;
    assign o_hit       = r_hit;

    a_hit_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_hit) |-> (r_distance < r_max_range))
        else $error("hit reported at or beyond max range");

endmodule
